### src/i2c_master_transaction_sequencer_top_macros.svh
// Assertion macros used by the sequencer's checker file.
`ifndef I2C_MASTER_TRANSACTION_SEQUENCER_TOP_MACROS_SVH
`define I2C_MASTER_TRANSACTION_SEQUENCER_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SEQ_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sequencer assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define SEQ_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sequencer assertion failed");

`endif

### src/i2cmts_pkg.sv
// Types and codes of the I2C master transaction sequencer.
package i2cmts_pkg;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_WRITE = 2'd1,
      OP_READ  = 2'd2,
      OP_EVENT = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      MODE_READY = 2'd0,
      MODE_WRITE = 2'd1,
      MODE_READ  = 2'd2
   } mode_type;

   typedef enum logic [3:0] {
      EV_START        = 4'd0,
      EV_REP_START    = 4'd1,
      EV_WR_ADDR_ACK  = 4'd2,
      EV_WR_ADDR_NACK = 4'd3,
      EV_WR_DATA_ACK  = 4'd4,
      EV_WR_DATA_NACK = 4'd5,
      EV_ARB_LOST     = 4'd6,
      EV_RD_ADDR_ACK  = 4'd7,
      EV_RD_ADDR_NACK = 4'd8,
      EV_RD_DATA_ACK  = 4'd9,
      EV_RD_DATA_NACK = 4'd10,
      EV_NO_INFO      = 4'd11,
      EV_BUS_ERROR    = 4'd12
   } event_type;

   typedef enum logic [3:0] {
      CMD_NONE     = 4'd0,
      CMD_START    = 4'd1,
      CMD_ADDR     = 4'd2,
      CMD_DATA     = 4'd3,
      CMD_ACK      = 4'd4,
      CMD_NACK     = 4'd5,
      CMD_STOP     = 4'd6,
      CMD_RELEASE  = 4'd7,
      CMD_REPSTART = 4'd8
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_ADDR_NACK = 3'd1,
      ST_DATA_NACK = 3'd2,
      ST_OTHER     = 3'd3,
      ST_BUSY      = 3'd4,
      ST_LENGTH    = 3'd5
   } status_type;

   // Receive count saturates here.
   localparam logic [5:0] IDX_MAX = 6'd63;

endpackage

### src/i2c_master_transaction_sequencer_top.sv
// Top level of the I2C master transaction sequencer.
//
// The block sits above a byte-level I2C bus engine. Each beat on the request
// channel (req_*) is one of: a transmit-buffer load, a begin-write, a
// begin-read, or a status event reported by the bus engine. Every request beat
// produces exactly one response beat on the rsp_* channel carrying the next
// bus command and its byte, any received byte, the running receive count,
// transaction completion, a status code and the busy flag.
//
// A beat is taken on a rising edge where valid is high and stall is low.
// The request is registered, decoded against the transaction state by short
// logic, and the response registered. One beat per cycle is sustained while
// rsp_stall is low: the input register can take a beat while a finished
// response waits in the output register, and stall only reaches the requester
// when both registers are full and the consumer holds rsp_stall. The transmit
// buffer is a small memory whose read port prefetches the entry at the next
// byte index, so a data send does not wait on the buffer read.
//
// Synchronous reset empties both registers and returns the sequencer to the
// ready mode with STOP as the default ending; buffer contents are kept.
module i2c_master_transaction_sequencer_top #(
   parameter int BUFFER_DEPTH = 32
) (
   input  logic       clock,
   input  logic       reset,

   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_operation,
   input  logic [6:0] req_target_address,
   input  logic [5:0] req_byte_count,
   input  logic       req_finish_with_stop,
   input  logic [4:0] req_load_slot,
   input  logic [7:0] req_data_byte,
   input  logic [3:0] req_bus_event,

   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [3:0] rsp_bus_command,
   output logic [7:0] rsp_command_byte,
   output logic       rsp_rx_valid,
   output logic [7:0] rsp_rx_byte,
   output logic [5:0] rsp_rx_total,
   output logic       rsp_done_res,
   output logic [2:0] rsp_status_code,
   output logic       rsp_busy_res
);
   import i2cmts_pkg::*;

   localparam int ADDR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam logic [8:0] DEPTH_V = 9'(BUFFER_DEPTH);

   // Input register.
   logic       s1_valid_ff, s1_valid_in;
   op_type     op_ff;
   logic [6:0] target_ff;
   logic [5:0] count_ff;
   logic       fstop_ff;
   logic [4:0] slot_ff;
   logic [7:0] data_ff;
   logic [3:0] event_ff;

   // Transaction state.
   mode_type   mode_ff, mode_in;
   logic [7:0] addr_byte_ff, addr_byte_in;
   logic       stop_at_end_ff, stop_at_end_in;
   logic       rs_pending_ff, rs_pending_in;
   logic [2:0] err_kind_ff, err_kind_in;
   logic [5:0] byte_index_ff, byte_index_in;
   logic [5:0] byte_limit_ff, byte_limit_in;

   // Transmit buffer and its prefetched read data.
   logic [7:0] tx_buf [BUFFER_DEPTH];
   logic [7:0] tx_rdata_ff;
   logic       buf_wr;
   logic [ADDR_W-1:0] buf_waddr, buf_raddr;

   // Output register.
   logic       rsp_valid_ff, rsp_valid_in;
   cmd_type    cmd_ff, cmd_in;
   logic [7:0] cbyte_ff, cbyte_in;
   logic       rxv_ff, rxv_in;
   logic [7:0] rxb_ff, rxb_in;
   logic [5:0] rxt_ff, rxt_in;
   logic       done_ff, done_in;
   status_type st_ff, st_in;
   logic       busy_ff, busy_in;

   logic       advance;

   // Decode helpers.
   logic       is_begin, begin_rd, len_bad, begin_ok, load_ok, active;
   logic       is_wr, is_rd, wr_more, rd_more_now, rd_more_next;
   logic [5:0] idx_inc, idx_sat;
   logic [7:0] new_addr_byte;

   // The result register can take a new beat when it is empty or being drained.
   assign advance      = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall    = s1_valid_ff && !advance;
   assign s1_valid_in  = (req_valid && !req_stall) || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   assign active     = (mode_ff != MODE_READY);
   assign is_wr      = (mode_ff == MODE_WRITE);
   assign is_rd      = (mode_ff == MODE_READ);
   assign is_begin   = (op_ff == OP_WRITE) || (op_ff == OP_READ);
   assign begin_rd   = (op_ff == OP_READ);
   assign len_bad    = ({3'b000, count_ff} > DEPTH_V) || (begin_rd && (count_ff == 6'd0));
   assign begin_ok   = is_begin && !len_bad && !active;
   assign load_ok    = (op_ff == OP_LOAD) && !active && ({4'b0000, slot_ff} < DEPTH_V);
   assign new_addr_byte = {target_ff, begin_rd};

   assign wr_more      = (byte_index_ff < byte_limit_ff) && ({3'b000, byte_index_ff} < DEPTH_V);
   assign idx_inc      = 6'(byte_index_ff + 6'd1);
   assign idx_sat      = (byte_index_ff < IDX_MAX) ? idx_inc : byte_index_ff;
   assign rd_more_now  = (byte_index_ff < byte_limit_ff);
   assign rd_more_next = (idx_sat < byte_limit_ff);

   // Next transaction state.
   always_comb begin
      mode_in        = mode_ff;
      addr_byte_in   = addr_byte_ff;
      stop_at_end_in = stop_at_end_ff;
      rs_pending_in  = rs_pending_ff;
      err_kind_in    = err_kind_ff;
      byte_index_in  = byte_index_ff;
      byte_limit_in  = byte_limit_ff;
      if (advance) begin
         if (begin_ok) begin
            mode_in        = begin_rd ? MODE_READ : MODE_WRITE;
            stop_at_end_in = fstop_ff;
            err_kind_in    = ST_OK;
            byte_index_in  = 6'd0;
            byte_limit_in  = begin_rd ? 6'(count_ff - 6'd1) : count_ff;
            addr_byte_in   = new_addr_byte;
            rs_pending_in  = 1'b0;
         end else if (op_ff == OP_EVENT && active) begin
            case (event_ff)
               EV_WR_ADDR_ACK, EV_WR_DATA_ACK: begin
                  if (is_wr) begin
                     if (wr_more) begin
                        byte_index_in = idx_inc;
                     end else begin
                        mode_in = MODE_READY;
                        if (!stop_at_end_ff) rs_pending_in = 1'b1;
                     end
                  end
               end
               EV_WR_ADDR_NACK, EV_WR_DATA_NACK: begin
                  if (is_wr) begin
                     err_kind_in = (event_ff == EV_WR_ADDR_NACK) ? ST_ADDR_NACK : ST_DATA_NACK;
                     mode_in     = MODE_READY;
                  end
               end
               EV_ARB_LOST, EV_BUS_ERROR: begin
                  err_kind_in = ST_OTHER;
                  mode_in     = MODE_READY;
               end
               EV_RD_ADDR_NACK: begin
                  if (is_rd) begin
                     err_kind_in = ST_ADDR_NACK;
                     mode_in     = MODE_READY;
                  end
               end
               EV_RD_DATA_ACK, EV_RD_DATA_NACK: begin
                  if (is_rd) begin
                     byte_index_in = idx_sat;
                     if (event_ff == EV_RD_DATA_NACK) begin
                        mode_in = MODE_READY;
                        if (!stop_at_end_ff) rs_pending_in = 1'b1;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   // Response fields for the beat in the input register.
   always_comb begin
      cmd_in   = CMD_NONE;
      cbyte_in = 8'h00;
      rxv_in   = 1'b0;
      rxb_in   = 8'h00;
      rxt_in   = 6'd0;
      done_in  = 1'b0;
      st_in    = ST_OK;
      case (op_ff)
         OP_LOAD: begin
            if (active) st_in = ST_BUSY;
         end
         OP_WRITE, OP_READ: begin
            if (len_bad) begin
               st_in = ST_LENGTH;
            end else if (active) begin
               st_in = ST_BUSY;
            end else if (rs_pending_ff) begin
               // A repeated START is already on the bus: go straight to the address.
               cmd_in   = CMD_ADDR;
               cbyte_in = new_addr_byte;
            end else begin
               cmd_in = CMD_START;
            end
         end
         OP_EVENT: begin
            if (active) begin
               case (event_ff)
                  EV_START, EV_REP_START: begin
                     cmd_in   = CMD_ADDR;
                     cbyte_in = addr_byte_ff;
                  end
                  EV_WR_ADDR_ACK, EV_WR_DATA_ACK: begin
                     if (is_wr) begin
                        if (wr_more) begin
                           cmd_in   = CMD_DATA;
                           cbyte_in = tx_rdata_ff;
                        end else begin
                           cmd_in  = stop_at_end_ff ? CMD_STOP : CMD_REPSTART;
                           done_in = 1'b1;
                        end
                     end
                  end
                  EV_WR_ADDR_NACK, EV_WR_DATA_NACK: begin
                     if (is_wr) begin
                        cmd_in  = CMD_STOP;
                        done_in = 1'b1;
                     end
                  end
                  EV_ARB_LOST: begin
                     cmd_in  = CMD_RELEASE;
                     done_in = 1'b1;
                  end
                  EV_RD_ADDR_ACK: begin
                     if (is_rd) cmd_in = rd_more_now ? CMD_ACK : CMD_NACK;
                  end
                  EV_RD_ADDR_NACK: begin
                     if (is_rd) begin
                        cmd_in  = CMD_STOP;
                        done_in = 1'b1;
                     end
                  end
                  EV_RD_DATA_ACK: begin
                     if (is_rd) begin
                        rxv_in = 1'b1;
                        rxb_in = data_ff;
                        cmd_in = rd_more_next ? CMD_ACK : CMD_NACK;
                     end
                  end
                  EV_RD_DATA_NACK: begin
                     if (is_rd) begin
                        rxv_in  = 1'b1;
                        rxb_in  = data_ff;
                        cmd_in  = stop_at_end_ff ? CMD_STOP : CMD_REPSTART;
                        done_in = 1'b1;
                     end
                  end
                  EV_BUS_ERROR: begin
                     cmd_in  = CMD_STOP;
                     done_in = 1'b1;
                  end
                  EV_NO_INFO: begin
                  end
                  default: begin
                  end
               endcase
               if (is_rd) rxt_in = byte_index_in;
               if (done_in) st_in = status_type'(err_kind_in);
            end
         end
         default: begin
         end
      endcase
      busy_in = (mode_in != MODE_READY);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         mode_ff        <= MODE_READY;
         addr_byte_ff   <= 8'h00;
         stop_at_end_ff <= 1'b1;
         rs_pending_ff  <= 1'b0;
         err_kind_ff    <= ST_OK;
         byte_index_ff  <= 6'd0;
         byte_limit_ff  <= 6'd0;
      end else begin
         s1_valid_ff    <= s1_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         mode_ff        <= mode_in;
         addr_byte_ff   <= addr_byte_in;
         stop_at_end_ff <= stop_at_end_in;
         rs_pending_ff  <= rs_pending_in;
         err_kind_ff    <= err_kind_in;
         byte_index_ff  <= byte_index_in;
         byte_limit_ff  <= byte_limit_in;
      end
   end

   // Input payload register.
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         op_ff     <= op_type'(req_operation);
         target_ff <= req_target_address;
         count_ff  <= req_byte_count;
         fstop_ff  <= req_finish_with_stop;
         slot_ff   <= req_load_slot;
         data_ff   <= req_data_byte;
         event_ff  <= req_bus_event;
      end
   end

   // Output payload register.
   always_ff @(posedge clock) begin
      if (advance) begin
         cmd_ff   <= cmd_in;
         cbyte_ff <= cbyte_in;
         rxv_ff   <= rxv_in;
         rxb_ff   <= rxb_in;
         rxt_ff   <= rxt_in;
         done_ff  <= done_in;
         st_ff    <= st_in;
         busy_ff  <= busy_in;
      end
   end

   // Transmit buffer. The read port always fetches the entry at the byte index
   // the next beat will see; a load to that same entry is forwarded.
   assign buf_wr    = advance && load_ok;
   assign buf_waddr = ADDR_W'(slot_ff);
   assign buf_raddr = ADDR_W'(byte_index_in);

   always_ff @(posedge clock) begin
      if (buf_wr) tx_buf[buf_waddr] <= data_ff;
      if (buf_wr && (buf_waddr == buf_raddr)) begin
         tx_rdata_ff <= data_ff;
      end else begin
         tx_rdata_ff <= tx_buf[buf_raddr];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_bus_command  = cmd_ff;
   assign rsp_command_byte = cbyte_ff;
   assign rsp_rx_valid     = rxv_ff;
   assign rsp_rx_byte      = rxb_ff;
   assign rsp_rx_total     = rxt_ff;
   assign rsp_done_res     = done_ff;
   assign rsp_status_code  = st_ff;
   assign rsp_busy_res     = busy_ff;

endmodule

### src/i2cmts_checker.sv
// Port-level checker for the sequencer's response channel, with its bind.
`include "i2c_master_transaction_sequencer_top_macros.svh"

module i2cmts_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [3:0] rsp_bus_command,
   input logic [7:0] rsp_command_byte,
   input logic       rsp_rx_valid,
   input logic       rsp_done_res,
   input logic [2:0] rsp_status_code,
   input logic       rsp_busy_res
);
   import i2cmts_pkg::*;

   // A held response beat keeps its contents.
   `SEQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_bus_command) && $stable(rsp_command_byte))

   // Finishing a transaction always leaves the sequencer idle.
   `SEQ_ASSERT_NOW(a_done_idle, clock, reset, rsp_valid && rsp_done_res, !rsp_busy_res)

   // A finished transaction ends the bus activity with stop, release or repeated start.
   `SEQ_ASSERT_NOW(a_done_cmd, clock, reset, rsp_valid && rsp_done_res,
      rsp_bus_command == CMD_STOP || rsp_bus_command == CMD_RELEASE ||
      rsp_bus_command == CMD_REPSTART)

   // A received byte always comes with the answer for the next byte or the end.
   `SEQ_ASSERT_NOW(a_rx_cmd, clock, reset, rsp_valid && rsp_rx_valid,
      rsp_bus_command == CMD_ACK || rsp_bus_command == CMD_NACK ||
      rsp_bus_command == CMD_STOP || rsp_bus_command == CMD_REPSTART)

   // A request rejected as busy never drives the bus.
   `SEQ_ASSERT_NOW(a_busy_quiet, clock, reset, rsp_valid && (rsp_status_code == ST_BUSY),
      (rsp_bus_command == CMD_NONE) && !rsp_done_res)

endmodule

bind i2c_master_transaction_sequencer_top i2cmts_checker u_i2cmts_checker (.*);
